### hdl/ctw_pkg.sv
package ctw_pkg;

	localparam int COL_W = 7;
	localparam int ROW_W = 5;
	localparam int POS_W = COL_W + ROW_W;

	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [7:0]  ATTR_RESET  = 8'h0F;
	localparam logic [15:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] cell_data;
	} rsp_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             write_cell;
		logic             scroll;
	} cursor_upd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_SCROLL,
		ST_BLANK,
		ST_RDWAIT,
		ST_DONE
	} state_t;

endpackage

### hdl/text_console_writer.sv
// Text console for a COLUMNS x ROWS screen of 16-bit cells (attribute in the high byte,
// character in the low byte), held in one dual-port RAM with one write and one read port.
// Commands transfer one at a time and each returns one response with the cursor position.
// A character passes through EXEC and DONE, and a cell read through EXEC, RDWAIT and DONE.
// A character that pushes the cursor past the last row scrolls the screen (SCROLL, then
// BLANK for the last row), and a clear fills every cell; both are bounded by the RAM's
// single write port, one cell per cycle. After reset the RAM is blanked before the first
// command transfers; attribute writes are taken at any time.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  ctw_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ctw_pkg::rsp_t  rsp,
	input  logic           attr_we,
	input  logic [7:0]     attr_wdata
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int SCROLL_N = (ROWS - 1) * COLUMNS;

	ctw_pkg::state_t state_q, state_d;

	ctw_pkg::cmd_t                item_q;
	logic [ctw_pkg::COL_W-1:0]    col_q;
	logic [ctw_pkg::ROW_W-1:0]    row_q;
	logic [AW-1:0]                cnt_q;
	logic [7:0]                   attr_q;
	logic [15:0]                  data_q;
	ctw_pkg::cursor_upd_t         upd;
	logic [ctw_pkg::POS_W-1:0]    pos;
	logic                         read_ok;
	logic                         rsp_free;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [15:0]                  ram_wdata;
	logic [AW-1:0]                ram_raddr;
	logic [15:0]                  ram_rdata;
	logic [15:0]                  blank;

	ctw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.col      (col_q),
		.row      (row_q),
		.char_code(item_q.char_code),
		.upd      (upd)
	);

	ctw_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign pos = ctw_pkg::POS_W'(row_q) * ctw_pkg::POS_W'(COLUMNS) + ctw_pkg::POS_W'(col_q);
	assign read_ok  = 32'(item_q.cell_index) < CELLS;
	assign rsp_free = !rsp_valid || !rsp_stall;
	assign blank    = {attr_q, ctw_pkg::CH_SPACE};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctw_pkg::ST_INIT: begin
				if (cnt_q == AW'(CELLS - 1)) begin
					state_d = ctw_pkg::ST_IDLE;
				end
			end
			ctw_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ctw_pkg::ST_EXEC;
				end
			end
			ctw_pkg::ST_EXEC: begin
				case (item_q.kind)
					ctw_pkg::KIND_PUT:   state_d = upd.scroll ? ctw_pkg::ST_SCROLL : ctw_pkg::ST_DONE;
					ctw_pkg::KIND_CLEAR: state_d = ctw_pkg::ST_FILL;
					ctw_pkg::KIND_READ:  state_d = ctw_pkg::ST_RDWAIT;
					default:             state_d = ctw_pkg::ST_DONE;
				endcase
			end
			ctw_pkg::ST_FILL: begin
				if (cnt_q == AW'(CELLS - 1)) begin
					state_d = ctw_pkg::ST_DONE;
				end
			end
			ctw_pkg::ST_SCROLL: begin
				if (cnt_q == AW'(SCROLL_N)) begin
					state_d = ctw_pkg::ST_BLANK;
				end
			end
			ctw_pkg::ST_BLANK: begin
				if (cnt_q == AW'(CELLS - 1)) begin
					state_d = ctw_pkg::ST_DONE;
				end
			end
			ctw_pkg::ST_RDWAIT: begin
				state_d = ctw_pkg::ST_DONE;
			end
			ctw_pkg::ST_DONE: begin
				if (rsp_free) begin
					state_d = ctw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ctw_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		cmd_stall = (state_q != ctw_pkg::ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = blank;
		ram_raddr = '0;
		unique case (state_q)
			ctw_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = ctw_pkg::BLANK_RESET;
			end
			ctw_pkg::ST_EXEC: begin
				ram_we    = (item_q.kind == ctw_pkg::KIND_PUT) && upd.write_cell;
				ram_waddr = pos[AW-1:0];
				ram_wdata = {attr_q, item_q.char_code};
				ram_raddr = AW'(item_q.cell_index);
			end
			ctw_pkg::ST_FILL, ctw_pkg::ST_BLANK: begin
				ram_we = 1'b1;
			end
			ctw_pkg::ST_SCROLL: begin
				ram_we    = (cnt_q != '0);
				ram_waddr = cnt_q - AW'(1);
				ram_wdata = ram_rdata;
				ram_raddr = cnt_q + AW'(COLUMNS);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ctw_pkg::ST_INIT;
			cnt_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			attr_q    <= ctw_pkg::ATTR_RESET;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (attr_we) begin
				attr_q <= attr_wdata;
			end
			if (rsp_valid && !rsp_stall && state_q != ctw_pkg::ST_DONE) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ctw_pkg::ST_INIT, ctw_pkg::ST_FILL, ctw_pkg::ST_BLANK: begin
					cnt_q <= (cnt_q == AW'(CELLS - 1)) ? '0 : cnt_q + AW'(1);
				end
				ctw_pkg::ST_EXEC: begin
					cnt_q <= '0;
					if (item_q.kind == ctw_pkg::KIND_PUT) begin
						col_q <= upd.col;
						row_q <= upd.row;
					end else if (item_q.kind == ctw_pkg::KIND_CLEAR) begin
						col_q <= '0;
						row_q <= '0;
					end
				end
				ctw_pkg::ST_SCROLL: begin
					if (cnt_q != AW'(SCROLL_N)) begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ctw_pkg::ST_DONE: begin
					if (rsp_free) begin
						rsp_valid <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ctw_pkg::ST_IDLE && cmd_valid) begin
			item_q <= cmd;
		end
		if (state_q == ctw_pkg::ST_EXEC) begin
			data_q <= '0;
		end
		if (state_q == ctw_pkg::ST_RDWAIT) begin
			data_q <= read_ok ? ram_rdata : 16'h0000;
		end
		if (state_q == ctw_pkg::ST_DONE && rsp_free) begin
			rsp.cursor_pos <= pos[10:0];
			rsp.cell_data  <= data_q;
		end
	end

endmodule

### hdl/ctw_ram.sv
module ctw_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hdl/ctw_cursor.sv
module ctw_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic [ctw_pkg::COL_W-1:0] col,
	input  logic [ctw_pkg::ROW_W-1:0] row,
	input  logic [7:0]                char_code,
	output ctw_pkg::cursor_upd_t      upd
);

	logic [ctw_pkg::COL_W:0] nc;
	logic [ctw_pkg::ROW_W:0] nr;
	logic                    rinc;
	logic                    wr;

	always_comb begin
		nc   = {1'b0, col};
		rinc = 1'b0;
		wr   = 1'b0;
		if (char_code == ctw_pkg::CH_BS) begin
			if (col != '0) begin
				nc = {1'b0, col} - 1'b1;
			end
		end else if (char_code == ctw_pkg::CH_TAB) begin
			nc = {1'b0, col} + (ctw_pkg::COL_W + 1)'(8);
			nc[2:0] = 3'b000;
		end else if (char_code == ctw_pkg::CH_CR) begin
			nc = '0;
		end else if (char_code == ctw_pkg::CH_LF) begin
			nc   = '0;
			rinc = 1'b1;
		end else if (char_code >= ctw_pkg::CH_SPACE && char_code <= ctw_pkg::CH_DEL) begin
			wr = 1'b1;
			nc = {1'b0, col} + 1'b1;
		end
		if (32'(nc) >= COLUMNS) begin
			nc   = '0;
			rinc = 1'b1;
		end
		nr = {1'b0, row} + (ctw_pkg::ROW_W + 1)'(rinc);
		upd.col        = nc[ctw_pkg::COL_W-1:0];
		upd.write_cell = wr;
		if (32'(nr) >= ROWS) begin
			upd.row    = ctw_pkg::ROW_W'(ROWS - 1);
			upd.scroll = 1'b1;
		end else begin
			upd.row    = nr[ctw_pkg::ROW_W-1:0];
			upd.scroll = 1'b0;
		end
	end

endmodule

### hdl/ctw_checker.sv
module ctw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ctw_pkg::rsp_t rsp
);

	localparam int CELLS = COLUMNS * ROWS;

	// A response that is held back stays valid and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Commands are taken one at a time, so a transfer is followed by a busy cycle.
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command accepted while the previous one is in progress");

	// The reported cursor lies on the screen whenever the screen has at most 2048 cells.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.cursor_pos) < CELLS) || (CELLS > 2048))
		else $error("cursor position beyond the screen");

	// A new response never appears without a command being in progress.
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("response appeared while idle");

endmodule

bind text_console_writer ctw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_ctw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
